/* src/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RECC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define RECC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* src/recc_pkg.sv */
// types and constants shared by the exponent candidate check block
package recc_pkg;

  localparam int FACTOR_PORT_W = 16;
  localparam int WORD_W        = 32;

  typedef enum logic [1:0] {
    STATUS_CHECKED = 2'd0,
    STATUS_EQUAL   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [FACTOR_PORT_W-1:0] factor_a;
    logic [FACTOR_PORT_W-1:0] factor_b;
    logic [WORD_W-1:0]        random_word;
  } recc_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] exponent;
    logic [WORD_W-1:0] modulus;
    logic [WORD_W-1:0] totient;
    logic              accepted;
    status_t           status;
  } recc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_N,
    S_MUL_T,
    S_CHECK,
    S_REDUCE,
    S_COMPARE,
    S_GCD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_n;
    logic mul_t;
    logic red_start;
    logic set_e;
    logic gcd_init;
    logic gcd_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic e_eq_pi;
    logic div_done;
    logic rem_zero;
  } stat_t;

endpackage

/* src/recc_div.sv */
// bit-serial remainder unit, one quotient bit per cycle
`include "assert_macros.svh"

module recc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [recc_pkg::WORD_W-1:0]  dividend,
  input  logic [recc_pkg::WORD_W-1:0]  divisor,
  output logic                         done,
  output logic [recc_pkg::WORD_W-1:0]  rem
);

  localparam int CNT_W = $clog2(recc_pkg::WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(recc_pkg::WORD_W - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [recc_pkg::WORD_W-1:0]   dvd;
  logic [recc_pkg::WORD_W-1:0]   dsr;
  logic [recc_pkg::WORD_W:0]     trial;
  logic [recc_pkg::WORD_W:0]     diff;

  always_comb begin
    trial = {rem, dvd[recc_pkg::WORD_W-1]};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      // partial remainder stays below the divisor, so the top bit of diff is the borrow
      rem <= diff[recc_pkg::WORD_W] ? trial[recc_pkg::WORD_W-1:0]
                                    : diff[recc_pkg::WORD_W-1:0];
      dvd <= dvd << 1;
    end
  end

  `RECC_NEVER(a_no_restart, clk, rst, start && busy, "remainder unit restarted while busy")
  `RECC_NEVER(a_done_idle, clk, rst, done && busy, "remainder unit done while still busy")

endmodule

/* src/recc_dpath.sv */
// datapath: factor and product registers, candidate, euclid divisor and result register
module recc_dpath #(
  parameter int FACTOR_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  recc_pkg::cmd_t      cmd,
  input  recc_pkg::recc_in_t  in_data,
  output recc_pkg::stat_t     st,
  output recc_pkg::recc_out_t out_data
);

  localparam int FW = recc_pkg::FACTOR_PORT_W;
  localparam int EFF_W = (FACTOR_WIDTH < FW) ? FACTOR_WIDTH : FW;
  localparam logic [FW-1:0] FACTOR_MASK = FW'((33'd1 << EFF_W) - 33'd1);
  localparam int W = recc_pkg::WORD_W;

  logic [FW-1:0] p;
  logic [FW-1:0] q;
  logic [W-1:0]  rnd;
  logic [W-1:0]  n;
  logic [W-1:0]  pi;
  logic [W-1:0]  e;
  logic [W-1:0]  b;

  logic [FW-1:0] mul_x;
  logic [FW-1:0] mul_y;
  logic [W-1:0]  prod;

  logic          div_start;
  logic [W-1:0]  div_dividend;
  logic [W-1:0]  div_divisor;
  logic          div_done;
  logic [W-1:0]  div_rem;
  logic [W-1:0]  big;
  logic [W-1:0]  little;

  recc_pkg::recc_out_t res;

  // one shared multiplier: modulus first, then totient
  always_comb begin
    mul_x = cmd.mul_t ? (p - 1'b1) : p;
    mul_y = cmd.mul_t ? (q - 1'b1) : q;
    prod  = W'(mul_x) * W'(mul_y);
  end

  always_comb begin
    big    = (e > pi) ? e : pi;
    little = (e > pi) ? pi : e;
    div_start    = cmd.red_start | cmd.gcd_init | cmd.gcd_next;
    div_dividend = rnd;
    div_divisor  = n - 1'b1;
    if (cmd.gcd_init) begin
      div_dividend = big;
      div_divisor  = little;
    end else if (cmd.gcd_next) begin
      div_dividend = b;
      div_divisor  = div_rem;
    end
  end

  recc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p   <= in_data.factor_a & FACTOR_MASK;
      q   <= in_data.factor_b & FACTOR_MASK;
      rnd <= in_data.random_word;
    end
    if (cmd.mul_n) begin
      n <= prod;
    end
    if (cmd.mul_t) begin
      pi <= ((p == '0) || (q == '0)) ? '0 : prod;
    end
    if (cmd.set_e) begin
      e <= div_rem + 1'b1;
    end
    if (cmd.gcd_init) begin
      b <= little;
    end else if (cmd.gcd_next) begin
      b <= div_rem;
    end
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  always_comb begin
    st.invalid  = (n < W'(2)) || (pi == '0);
    st.e_eq_pi  = (e == pi);
    st.div_done = div_done;
    st.rem_zero = (div_rem == '0);
  end

  always_comb begin
    res.modulus = n;
    res.totient = pi;
    if (st.invalid) begin
      res.exponent = '0;
      res.accepted = 1'b0;
      res.status   = recc_pkg::STATUS_INVALID;
    end else if (st.e_eq_pi) begin
      res.exponent = e;
      res.accepted = 1'b0;
      res.status   = recc_pkg::STATUS_EQUAL;
    end else begin
      res.exponent = e;
      res.accepted = (b == W'(1));
      res.status   = recc_pkg::STATUS_CHECKED;
    end
  end

endmodule

/* src/recc_ctrl.sv */
// controller state machine and output word valid flag
`include "assert_macros.svh"

module recc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  recc_pkg::stat_t  st,
  output recc_pkg::cmd_t   cmd
);

  recc_pkg::state_t state;
  recc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= recc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      recc_pkg::S_IDLE:    if (in_valid) state_next = recc_pkg::S_MUL_N;
      recc_pkg::S_MUL_N:   state_next = recc_pkg::S_MUL_T;
      recc_pkg::S_MUL_T:   state_next = recc_pkg::S_CHECK;
      recc_pkg::S_CHECK:   state_next = st.invalid ? recc_pkg::S_DONE : recc_pkg::S_REDUCE;
      recc_pkg::S_REDUCE:  if (st.div_done) state_next = recc_pkg::S_COMPARE;
      recc_pkg::S_COMPARE: state_next = st.e_eq_pi ? recc_pkg::S_DONE : recc_pkg::S_GCD;
      recc_pkg::S_GCD:     if (st.div_done && st.rem_zero) state_next = recc_pkg::S_DONE;
      recc_pkg::S_DONE:    if (!out_valid || out_ready) state_next = recc_pkg::S_IDLE;
      default:             state_next = recc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      recc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      recc_pkg::S_MUL_N:   cmd.mul_n = 1'b1;
      recc_pkg::S_MUL_T:   cmd.mul_t = 1'b1;
      recc_pkg::S_CHECK:   cmd.red_start = !st.invalid;
      recc_pkg::S_REDUCE:  cmd.set_e = st.div_done;
      recc_pkg::S_COMPARE: cmd.gcd_init = !st.e_eq_pi;
      // remainder not zero yet: shift divisor down and go again
      recc_pkg::S_GCD:     cmd.gcd_next = st.div_done && !st.rem_zero;
      recc_pkg::S_DONE:    cmd.out_load = !out_valid || out_ready;
      default:             cmd = '0;
    endcase
  end

  `RECC_ASSERT(a_load_free, clk, rst, cmd.out_load |-> (!out_valid || out_ready), "result word overwritten while waiting")
  `RECC_ASSERT(a_valid_from_done, clk, rst, $rose(out_valid) |-> ($past(state) == recc_pkg::S_DONE), "result word raised outside done state")
  `RECC_ASSERT(a_ready_idle, clk, rst, in_ready |-> (state == recc_pkg::S_IDLE), "input taken while busy")

endmodule

/* src/rsa_exponent_candidate_check_top.sv */
// top level of the exponent candidate check block
// Takes one word at a time: factors p and q and a random word. It forms n = p*q and
// the totient (p-1)*(q-1) on one shared 16x16 multiplier, reduces the random word
// to a candidate e = rnd mod (n-1) + 1 and then runs Euclid's remainder loop on e
// and the totient. Every remainder goes through one bit-serial remainder unit.
// Invalid operands go straight to the result, with no reduction and no loop. The
// result sits in an output register, so the next word is taken while the previous
// result still waits.
module rsa_exponent_candidate_check_top #(
  parameter int FACTOR_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  recc_pkg::recc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output recc_pkg::recc_out_t out_data
);

  recc_pkg::cmd_t  cmd;
  recc_pkg::stat_t st;

  recc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  recc_dpath #(
    .FACTOR_WIDTH (FACTOR_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .st       (st),
    .out_data (out_data)
  );

endmodule

/* tb/rsa_exponent_candidate_check_top_tb.sv */
// testbench for the exponent candidate check block, with its own predictor
`timescale 1ns / 1ps

module rsa_exponent_candidate_check_top_tb;

  localparam int FACTOR_WIDTH = 16;
  localparam logic [31:0] FACTOR_MASK = (FACTOR_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                        (32'd1 << FACTOR_WIDTH) - 32'd1;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_OFF_LEN = 2000;
  localparam int RANDOM_ITEMS = 370;

  typedef struct {
    recc_pkg::recc_in_t  stim;
    bit                  known;
    recc_pkg::recc_out_t want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  recc_pkg::recc_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  recc_pkg::recc_out_t out_data;

  recc_pkg::recc_out_t pending_checks[$];
  stim_row_t           directed_rows[$];
  int                  mismatch_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  hold_off_len = 0;
  bit                  hold_off_taken = 1'b0;
  int                  idle_cycles = 0;

  rsa_exponent_candidate_check_top #(
    .FACTOR_WIDTH(FACTOR_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // modulus, totient, reduced candidate and coprimality test for one word
  function automatic recc_pkg::recc_out_t predict_candidate_check(recc_pkg::recc_in_t w);
    recc_pkg::recc_out_t r;
    logic [31:0]         p;
    logic [31:0]         q;
    logic [31:0]         a;
    logic [31:0]         b;
    logic [31:0]         rem;
    p = {16'b0, w.factor_a} & FACTOR_MASK;
    q = {16'b0, w.factor_b} & FACTOR_MASK;
    r = '0;
    r.status = recc_pkg::STATUS_CHECKED;
    r.modulus = p * q;
    if (p != 0 && q != 0) r.totient = (p - 32'd1) * (q - 32'd1);
    if (r.modulus < 32'd2 || r.totient == 0) begin
      r.status = recc_pkg::STATUS_INVALID;
    end else begin
      r.exponent = (w.random_word % (r.modulus - 32'd1)) + 32'd1;
      if (r.exponent == r.totient) begin
        r.status = recc_pkg::STATUS_EQUAL;
      end else begin
        a = (r.exponent > r.totient) ? r.exponent : r.totient;
        b = (r.exponent > r.totient) ? r.totient : r.exponent;
        rem = a % b;
        while (rem != 0) begin
          a = b;
          b = rem;
          rem = a % b;
        end
        r.accepted = (b == 32'd1);
      end
    end
    return r;
  endfunction

  task automatic add_row(input logic [15:0] p, input logic [15:0] q,
                         input logic [31:0] rnd, input bit known,
                         input logic [31:0] exponent, input logic [31:0] modulus,
                         input logic [31:0] totient, input logic accepted,
                         input recc_pkg::status_t status);
    stim_row_t row;
    row.stim = '{factor_a: p, factor_b: q, random_word: rnd};
    row.known = known;
    row.want = '{exponent: exponent, modulus: modulus, totient: totient,
                 accepted: accepted, status: status};
    directed_rows.push_back(row);
  endtask

  task automatic send_word(input recc_pkg::recc_in_t w, input recc_pkg::recc_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_checks.push_back(want);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_len != 0 && !hold_off_taken) begin
        out_ready <= 1'b0;
        hold_off_taken = 1'b1;
        repeat (hold_off_len) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    recc_pkg::recc_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_checks.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        mismatch_count++;
      end else begin
        want = pending_checks.pop_front();
        if (out_data.exponent !== want.exponent) begin
          $error("exponent: expected %h, got %h", want.exponent, out_data.exponent);
          mismatch_count++;
        end
        if (out_data.modulus !== want.modulus) begin
          $error("modulus: expected %h, got %h", want.modulus, out_data.modulus);
          mismatch_count++;
        end
        if (out_data.totient !== want.totient) begin
          $error("totient: expected %h, got %h", want.totient, out_data.totient);
          mismatch_count++;
        end
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %b, got %b", want.accepted, out_data.accepted);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    recc_pkg::recc_in_t  w;
    recc_pkg::recc_out_t want;
    logic [31:0]         n;
    logic [31:0]         pi;
    logic [31:0]         e;
    logic [63:0]         rnd64;
    int                  kind;
    int                  per_phase;

    // invalid operands: zero factor, unit factor
    add_row(16'h0000, 16'h0000, 32'h0000_0000, 1, 0, 0, 0, 0, recc_pkg::STATUS_INVALID);
    add_row(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, recc_pkg::STATUS_INVALID);
    add_row(16'hFFFF, 16'h0000, 32'h1234_5678, 1, 0, 0, 0, 0, recc_pkg::STATUS_INVALID);
    add_row(16'h0001, 16'h0001, 32'hFFFF_FFFF, 1, 0, 32'd1, 0, 0,
            recc_pkg::STATUS_INVALID);
    add_row(16'h0001, 16'hFFFF, 32'h0000_0000, 1, 0, 32'hFFFF, 0, 0,
            recc_pkg::STATUS_INVALID);
    add_row(16'hFFFF, 16'h0001, 32'hAAAA_5555, 1, 0, 32'hFFFF, 0, 0,
            recc_pkg::STATUS_INVALID);
    add_row(16'h8000, 16'h0001, 32'h5555_AAAA, 1, 0, 32'h8000, 0, 0,
            recc_pkg::STATUS_INVALID);
    // candidate equal to totient
    add_row(16'h0002, 16'h0002, 32'h0000_0000, 1, 32'd1, 32'd4, 32'd1, 0,
            recc_pkg::STATUS_EQUAL);
    add_row(16'h0002, 16'h0003, 32'h0000_0001, 1, 32'd2, 32'd6, 32'd2, 0,
            recc_pkg::STATUS_EQUAL);
    add_row(16'hFFFF, 16'hFFFF, 32'hFFFC_0003, 1, 32'hFFFC_0004, 32'hFFFE_0001,
            32'hFFFC_0004, 0, recc_pkg::STATUS_EQUAL);
    // checked via the predictor
    add_row(16'h0002, 16'h0002, 32'h0000_0001, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'h0002, 16'h0002, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'h0003, 16'h0005, 32'h0000_0002, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'h0003, 16'h0003, 32'h0000_0001, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'hFFFF, 16'hFFFF, 32'h0000_0000, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'hFFFF, 16'hFFFF, 32'hFFFD_FFFF, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'h0002, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'hFFFF, 16'h0002, 32'h8000_0000, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'h8000, 16'h8000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'h5555, 16'hAAAA, 32'h5555_5555, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);
    add_row(16'hAAAB, 16'h5557, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, recc_pkg::STATUS_CHECKED);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      want = directed_rows[i].known ? directed_rows[i].want
                                    : predict_candidate_check(directed_rows[i].stim);
      send_word(directed_rows[i].stim, want);
    end
    wait_all_results();

    per_phase = RANDOM_ITEMS / 4;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          // long hold-off so the block fills and back-pressures its input
          hold_off_len = HOLD_OFF_LEN;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct = 36;
          recv_stall_pct = 36;
        end
      endcase
      for (int k = 0; k < per_phase; k++) begin
        kind = $urandom_range(99);
        w.factor_a = 16'($urandom_range(16'hFFFF, 2));
        w.factor_b = 16'($urandom_range(16'hFFFF, 2));
        w.random_word = $urandom;
        if (kind < 10) begin
          // noise: a zero or unit factor on either side
          if ($urandom_range(1)) w.factor_a = 16'($urandom_range(1));
          else w.factor_b = 16'($urandom_range(1));
        end else if (kind < 25) begin
          w.factor_a = 16'($urandom_range(40, 2));
          w.factor_b = 16'($urandom_range(40, 2));
        end else if (kind < 65) begin
          if (kind < 35) begin
            w.factor_a = 16'($urandom_range(300, 2));
            w.factor_b = 16'($urandom_range(300, 2));
          end
          n = ({16'b0, w.factor_a} & FACTOR_MASK) * ({16'b0, w.factor_b} & FACTOR_MASK);
          pi = (({16'b0, w.factor_a} & FACTOR_MASK) - 32'd1) *
               (({16'b0, w.factor_b} & FACTOR_MASK) - 32'd1);
          if (kind < 45) begin
            // aim the candidate at the totient itself
            e = pi;
          end else begin
            // golden-ratio candidate for a long remainder chain
            e = 32'((64'(pi) * 64'd40503) >> 16) + $urandom_range(3);
            if (e == 0) e = 32'd1;
          end
          rnd64 = 64'(e) - 64'd1 + 64'($urandom_range(3)) * 64'(n - 32'd1);
          w.random_word = (rnd64 > 64'hFFFF_FFFF) ? e - 32'd1 : rnd64[31:0];
        end
        send_word(w, predict_candidate_check(w));
      end
      // sender pauses until every expected result word is back
      wait_all_results();
    end

    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/recc_pkg.sv
src/recc_div.sv
src/recc_dpath.sv
src/recc_ctrl.sv
src/rsa_exponent_candidate_check_top.sv
tb/rsa_exponent_candidate_check_top_tb.sv
